/* src/baro_temp_pressure_compensation_assert.svh */
// Assertion macros used by the compensation block's checker
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// checked only while out of reset
`define BTPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BTPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/btpc_pkg.sv */
// Shared constants and types of the barometric compensation pipeline
package btpc_pkg;

	localparam int RawW    = 20;
	localparam int TcW     = 15;
	localparam int PresW   = 32;
	localparam int WordW   = 64;
	localparam int TcalW   = 48;
	localparam int P9W     = 16;
	localparam int CfgIdxW = 3;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_TEMP_CAL   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PRES_LOW   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PRES_HIGH  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PRES_LAST  = 3'd3;

	// temperature output limits, 0.01 degC
	localparam logic signed [TcW-1:0] TC_MIN = -15'sd4000;
	localparam logic signed [TcW-1:0] TC_MAX = 15'sd8500;

	// sideband that travels with an item through the divider and after it
	typedef struct packed {
		logic                  vld;
		logic signed [TcW-1:0] tc;
		logic                  neg;
		logic                  dz;
	} btpc_side_t;

endpackage

/* src/btpc_div.sv */
// Pipelined 64-bit unsigned restoring divider, one quotient bit per stage
module btpc_div import btpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  btpc_side_t       side_in,
	input  logic [WordW-1:0] dividend,
	input  logic [WordW-1:0] divisor,
	output btpc_side_t       side_out,
	output logic [WordW-1:0] quot
);

	btpc_side_t       side_st [WordW];
	logic [WordW-1:0] rem_st  [WordW];
	logic [WordW-1:0] nq_st   [WordW];
	logic [WordW-1:0] dsr_st  [WordW];

	for (genvar g = 0; g < WordW; g++) begin : g_step
		logic [WordW-1:0] rem_in;
		logic [WordW-1:0] nq_in;
		logic [WordW-1:0] dsr_in;
		btpc_side_t       side_i;
		logic [WordW:0]   trial;
		logic [WordW:0]   diff;
		logic             take;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = dividend;
			assign dsr_in = divisor;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_in = rem_st[g-1];
			assign nq_in  = nq_st[g-1];
			assign dsr_in = dsr_st[g-1];
			assign side_i = side_st[g-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {rem_in, nq_in[WordW-1]};
		assign diff  = trial - {1'b0, dsr_in};
		assign take  = (trial >= {1'b0, dsr_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_st[g] <= '0;
			end else if (en) begin
				side_st[g] <= side_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[g] <= take ? diff[WordW-1:0] : trial[WordW-1:0];
				nq_st[g]  <= {nq_in[WordW-2:0], take};
				dsr_st[g] <= dsr_in;
			end
		end
	end

	assign side_out = side_st[WordW-1];
	assign quot     = nq_st[WordW-1];

endmodule

/* src/baro_temp_pressure_compensation.sv */
// Barometric temperature / pressure compensation pipeline (top level)
// Takes one raw temperature/pressure pair per cycle and returns compensated
// temperature (0.01 degC, saturated to -4000..8500) and pressure (Pa, unsigned
// Q24.8, saturated), with a flag when the pressure divisor is zero. The path
// has 12 polynomial stages, 64 stages of the bit-per-stage unsigned divider,
// 5 stages of the pressure correction terms and the output register.
// Throughput is one beat per cycle; the whole pipeline holds, bubbles
// included, while a result waits at the output and out_ready is low.
// Calibration is written through the cfg channel, which is always ready;
// write it only while no beat is in flight.
module baro_temp_pressure_compensation import btpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CfgIdxW-1:0]    cfg_index,
	input  logic [WordW-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RawW-1:0]       raw_temperature,
	input  logic [RawW-1:0]       raw_pressure,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [TcW-1:0] temperature_centi,
	output logic [PresW-1:0]      pressure_q24_8,
	output logic                  divide_by_zero
);

	// calibration registers
	logic [TcalW-1:0] temp_cal_q;
	logic [WordW-1:0] pres_low_q;
	logic [WordW-1:0] pres_high_q;
	logic [P9W-1:0]   pres_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q  <= '0;
			pres_low_q  <= '0;
			pres_high_q <= '0;
			pres_last_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TEMP_CAL:  temp_cal_q  <= cfg_data[TcalW-1:0];
				CFG_PRES_LOW:  pres_low_q  <= cfg_data;
				CFG_PRES_HIGH: pres_high_q <= cfg_data;
				CFG_PRES_LAST: pres_last_q <= cfg_data[P9W-1:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_cal_q[15:0];
	assign t2 = temp_cal_q[31:16];
	assign t3 = temp_cal_q[47:32];
	assign p1 = pres_low_q[15:0];
	assign p2 = pres_low_q[31:16];
	assign p3 = pres_low_q[47:32];
	assign p4 = pres_low_q[63:48];
	assign p5 = pres_high_q[15:0];
	assign p6 = pres_high_q[31:16];
	assign p7 = pres_high_q[47:32];
	assign p8 = pres_high_q[63:48];
	assign p9 = pres_last_q;

	// global advance: hold only when the output beat is stuck
	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// valid bits of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// stage 1: temperature offsets
	logic signed [17:0] ta_c, ta_s1;
	logic signed [16:0] d_c, d_s1;
	logic [RawW-1:0]    ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8, ap_s9;

	assign ta_c = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d_c  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});

	// stage 2: linear and square temperature products
	logic signed [33:0] tprod_c, tprod_s2, dd_c;
	logic [32:0]        dd_s2;

	assign tprod_c = ta_s1 * t2;
	assign dd_c    = d_s1 * d_s1;

	// stage 3: scale down
	logic signed [22:0] taa_s3, taa_s4;
	logic [20:0]        dd12_s3;

	// stage 4: quadratic term
	logic signed [37:0] b2_c, b2_s4;

	assign b2_c = $signed({1'b0, dd12_s3}) * t3;

	// stage 5: fine temperature
	logic signed [24:0] fine_c, fine_s5;

	assign fine_c = taa_s4 + $signed(b2_s4[37:14]);

	// stage 6: centidegrees with clamp, pressure offset
	logic signed [27:0]    tc5_c;
	logic signed [19:0]    tcw_c;
	logic signed [TcW-1:0] tc_c;
	logic signed [25:0]    pa_c, pa_s6;
	logic signed [TcW-1:0] tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12;

	assign tc5_c = fine_s5 * 28'sd5 + 28'sd128;
	assign tcw_c = tc5_c[27:8];
	assign pa_c  = fine_s5 - 26'sd128000;

	always_comb begin
		if (tcw_c < TC_MIN) begin
			tc_c = TC_MIN;
		end else if (tcw_c > TC_MAX) begin
			tc_c = TC_MAX;
		end else begin
			tc_c = tcw_c[TcW-1:0];
		end
	end

	// stage 7: first pressure products
	logic signed [51:0] aa_c, aa_s7;
	logic signed [41:0] ap5_c, ap2_c, ap5_s7, ap2_s7, ap5_s8, ap2_s8;

	assign aa_c  = pa_s6 * pa_s6;
	assign ap5_c = pa_s6 * p5;
	assign ap2_c = pa_s6 * p2;

	// stage 8: square times coefficients, wrapped to 64 bits
	logic signed [67:0] aap6_c, aap3_c;
	logic [WordW-1:0]   aap6_s8, aap3_s8;

	assign aap6_c = aa_s7 * p6;
	assign aap3_c = aa_s7 * p3;

	// stage 9: divisor-side and numerator-side sums
	logic [WordW-1:0] b_c, a2_c, b_s9, a2_s9;

	assign b_c  = aap6_s8 + ({{22{ap5_s8[41]}}, ap5_s8} << 17)
		+ ({{48{p4[15]}}, p4} << 35);
	assign a2_c = {{8{aap3_s8[63]}}, aap3_s8[63:8]} + ({{22{ap2_s8[41]}}, ap2_s8} << 12);

	// stage 10: divisor product, raw numerator
	logic [WordW-1:0] x_c, prod_s10, num0_c, num0_s10;
	logic [79:0]      prod_c;
	logic [20:0]      pdiff_c;

	assign x_c     = (64'd1 << 47) + a2_s9;
	assign prod_c  = x_c * p1;
	assign pdiff_c = 21'h100000 - {1'b0, ap_s9};
	assign num0_c  = ({43'd0, pdiff_c} << 31) - b_s9;

	// stage 11: divisor, scaled numerator
	logic [WordW-1:0] a1_c, a1_s11, num_s11;
	logic [75:0]      num_c;

	assign a1_c  = {{33{prod_s10[63]}}, prod_s10[63:33]};
	assign num_c = num0_s10 * 12'd3125;

	// stage 12: magnitudes and sign for the divider
	logic [WordW-1:0] ma_s12, mb_s12;
	logic             neg_s12, dz_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1    <= ta_c;
			d_s1     <= d_c;
			ap_s1    <= raw_pressure;
			tprod_s2 <= tprod_c;
			dd_s2    <= dd_c[32:0];
			ap_s2    <= ap_s1;
			taa_s3   <= tprod_s2[33:11];
			dd12_s3  <= dd_s2[32:12];
			ap_s3    <= ap_s2;
			taa_s4   <= taa_s3;
			b2_s4    <= b2_c;
			ap_s4    <= ap_s3;
			fine_s5  <= fine_c;
			ap_s5    <= ap_s4;
			tc_s6    <= tc_c;
			pa_s6    <= pa_c;
			ap_s6    <= ap_s5;
			aa_s7    <= aa_c;
			ap5_s7   <= ap5_c;
			ap2_s7   <= ap2_c;
			tc_s7    <= tc_s6;
			ap_s7    <= ap_s6;
			aap6_s8  <= aap6_c[63:0];
			aap3_s8  <= aap3_c[63:0];
			ap5_s8   <= ap5_s7;
			ap2_s8   <= ap2_s7;
			tc_s8    <= tc_s7;
			ap_s8    <= ap_s7;
			b_s9     <= b_c;
			a2_s9    <= a2_c;
			tc_s9    <= tc_s8;
			ap_s9    <= ap_s8;
			prod_s10 <= prod_c[63:0];
			num0_s10 <= num0_c;
			tc_s10   <= tc_s9;
			a1_s11   <= a1_c;
			num_s11  <= num_c[63:0];
			tc_s11   <= tc_s10;
			ma_s12   <= num_s11[63] ? (64'd0 - num_s11) : num_s11;
			mb_s12   <= a1_s11[63] ? (64'd0 - a1_s11) : a1_s11;
			neg_s12  <= num_s11[63] ^ a1_s11[63];
			dz_s12   <= (a1_s11 == 64'd0);
			tc_s12   <= tc_s11;
		end
	end

	// signed division, truncating toward zero
	btpc_side_t       side_dv_in, side_dv;
	logic [WordW-1:0] q_dv;

	always_comb begin
		side_dv_in.vld = v_s12;
		side_dv_in.tc  = tc_s12;
		side_dv_in.neg = neg_s12;
		side_dv_in.dz  = dz_s12;
	end

	btpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_dv_in),
		.dividend (ma_s12),
		.divisor  (mb_s12),
		.side_out (side_dv),
		.quot     (q_dv)
	);

	// back-end sideband
	btpc_side_t side_s13, side_s14, side_s15, side_s16, side_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s13 <= '0;
			side_s14 <= '0;
			side_s15 <= '0;
			side_s16 <= '0;
			side_s17 <= '0;
		end else if (en) begin
			side_s13 <= side_dv;
			side_s14 <= side_s13;
			side_s15 <= side_s14;
			side_s16 <= side_s15;
			side_s17 <= side_s16;
		end
	end

	// stage 14: split square of the scaled quotient, linear correction
	logic signed [WordW-1:0] p_s13, p_s14, p_s15, p_s16, ps_c;
	logic [63:0]             ll_c, ll_s14;
	logic [31:0]             lh_c, hl_c, lh_s14, hl_s14;
	logic signed [79:0]      c8_c;
	logic [WordW-1:0]        c8_s14, c8_s15, c8_s16;

	assign ps_c = p_s13 >>> 13;
	assign ll_c = ps_c[31:0] * ps_c[31:0];
	assign lh_c = ps_c[31:0] * ps_c[63:32];
	assign hl_c = ps_c[63:32] * ps_c[31:0];
	assign c8_c = p_s13 * p8;

	// stage 15: rebuild the low 64 bits of the square
	logic [WordW-1:0] pss_c, pss_s15;
	logic [31:0]      cross_c;

	assign cross_c = lh_s14 + hl_s14;
	assign pss_c   = ll_s14 + {cross_c, 32'd0};

	// stage 16: second-order correction product
	logic signed [79:0] c9_c;
	logic [WordW-1:0]   c9_s16;

	assign c9_c = $signed(pss_s15) * p9;

	// stage 17: add corrections
	logic [WordW-1:0] sum_c, sum_s17;

	assign sum_c = p_s16 + {{25{c9_s16[63]}}, c9_s16[63:25]}
		+ {{19{c8_s16[63]}}, c8_s16[63:19]};

	// output: offset, clamp, zero-divisor override
	logic [WordW-1:0]  pr_c;
	logic [PresW-1:0]  pres_c;

	assign pr_c = {{8{sum_s17[63]}}, sum_s17[63:8]} + ({{48{p7[15]}}, p7} << 4);

	always_comb begin
		if (side_s17.dz || pr_c[63]) begin
			pres_c = '0;
		end else if (|pr_c[63:32]) begin
			pres_c = '1;
		end else begin
			pres_c = pr_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s13   <= side_dv.neg ? (64'd0 - q_dv) : q_dv;
			p_s14   <= p_s13;
			ll_s14  <= ll_c;
			lh_s14  <= lh_c;
			hl_s14  <= hl_c;
			c8_s14  <= c8_c[63:0];
			p_s15   <= p_s14;
			pss_s15 <= pss_c;
			c8_s15  <= c8_s14;
			p_s16   <= p_s15;
			c9_s16  <= c9_c[63:0];
			c8_s16  <= c8_s15;
			sum_s17 <= sum_c;
		end
	end

	// output register
	logic signed [TcW-1:0] tc_q;
	logic [PresW-1:0]      pres_q;
	logic                  dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_s17.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc_q   <= side_s17.tc;
			pres_q <= pres_c;
			dz_q   <= side_s17.dz;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = tc_q;
	assign pressure_q24_8    = pres_q;
	assign divide_by_zero    = dz_q;

endmodule

/* src/btpc_checker.sv */
// Port-level checker for the compensation block, bound to the top level
module btpc_checker import btpc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [RawW-1:0]       raw_temperature,
	input logic [RawW-1:0]       raw_pressure,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic signed [TcW-1:0] temperature_centi,
	input logic [PresW-1:0]      pressure_q24_8,
	input logic                  divide_by_zero
);

`include "baro_temp_pressure_compensation_assert.svh"

	// a stalled result beat holds its pressure and temperature
	`BTPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pressure_q24_8) && $stable(temperature_centi), "output beat changed while stalled")

	// a stalled input beat holds its payload
	`BTPC_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(raw_temperature) && $stable(raw_pressure), "input beat changed while stalled")

	// zero divisor forces pressure to zero
	`BTPC_ASSERT(a_dz_zero, out_valid && divide_by_zero |-> pressure_q24_8 == 32'd0, "pressure not zero on divide flag")

	// temperature stays inside its clamp
	`BTPC_ASSERT(a_tc_range, out_valid |-> temperature_centi >= TC_MIN && temperature_centi <= TC_MAX, "temperature outside clamp")

	// input stalls only behind a stuck output beat
	`BTPC_ASSERT_ALWAYS(a_in_stall, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (.*);

/* dv/baro_temp_pressure_compensation_tb.sv */
// Self-checking testbench for the barometric temperature / pressure compensation pipeline
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_tb;
	import btpc_pkg::*;

	localparam int LATENCY = 82;

	typedef struct {
		logic [RawW-1:0] rt;
		logic [RawW-1:0] rp;
	} raw_pair_t;

	typedef struct {
		logic [TcW-1:0]   tc;
		logic [PresW-1:0] pres;
		logic             dz;
	} comp_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [WordW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [RawW-1:0] raw_temperature = '0;
	logic [RawW-1:0] raw_pressure = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [TcW-1:0] temperature_centi;
	logic [PresW-1:0] pressure_q24_8;
	logic divide_by_zero;

	// calibration copy used by the predictor
	logic [TcalW-1:0] tcal;
	logic [WordW-1:0] pcal_lo, pcal_hi;
	logic [P9W-1:0] pcal_p9;

	raw_pair_t pending_pairs[$];
	comp_result_t expected_results[$];
	int errors = 0;
	int n_results = 0;
	int n_dz = 0;
	int n_sat = 0;
	int hold_off = 0;
	int in_gap = 0;
	int out_gap = 0;

	baro_temp_pressure_compensation u_dut (.*);

	always #2 clk = ~clk;

	function automatic logic signed [63:0] sx16(logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

	// integer compensation polynomials, 64-bit wrapping datapath
	function automatic comp_result_t compensate(raw_pair_t r);
		comp_result_t res;
		logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] at, ap, a, b, d, fine, tcs, p, ps, c9, c8;
		logic [63:0] ma, mb, q;
		t1 = {48'd0, tcal[15:0]};
		t2 = sx16(tcal[31:16]);
		t3 = sx16(tcal[47:32]);
		p1 = {48'd0, pcal_lo[15:0]};
		p2 = sx16(pcal_lo[31:16]);
		p3 = sx16(pcal_lo[47:32]);
		p4 = sx16(pcal_lo[63:48]);
		p5 = sx16(pcal_hi[15:0]);
		p6 = sx16(pcal_hi[31:16]);
		p7 = sx16(pcal_hi[47:32]);
		p8 = sx16(pcal_hi[63:48]);
		p9 = sx16(pcal_p9);
		at = {44'd0, r.rt};
		ap = {44'd0, r.rp};
		// temperature
		a = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (at >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		tcs = (fine * 5 + 128) >>> 8;
		if (tcs < -4000) tcs = -4000;
		if (tcs > 8500) tcs = 8500;
		res.tc = tcs[TcW-1:0];
		// pressure
		a = fine - 128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		res.dz = (a == 0);
		res.pres = '0;
		if (!res.dz) begin
			p = 1048576 - ap;
			p = ((p <<< 31) - b) * 3125;
			ma = p[63] ? -p : p;
			mb = a[63] ? -a : a;
			q = ma / mb;
			p = (p[63] != a[63]) ? -q : q;
			ps = p >>> 13;
			c9 = (p9 * ps * ps) >>> 25;
			c8 = (p8 * p) >>> 19;
			p = ((p + c9 + c8) >>> 8) + (p7 <<< 4);
			if (p < 0) res.pres = '0;
			else if (p > 64'sh0_FFFF_FFFF) res.pres = '1;
			else res.pres = p[31:0];
		end
		return res;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// input driver: one beat per handshake, random gaps (possibly none) between beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(compensate('{raw_temperature, raw_pressure}));
				in_gap = gap_len();
			end
			if ((in_valid && !in_ready)) begin
				// hold beat stable
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				raw_pair_t nx;
				nx = pending_pairs.pop_front();
				in_valid <= 1'b1;
				raw_temperature <= nx.rt;
				raw_pressure <= nx.rp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor and ready generator
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				comp_result_t e;
				n_results++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat tc=%0d p=%0h dz=%0b", $time,
						temperature_centi, pressure_q24_8, divide_by_zero);
				end else begin
					e = expected_results.pop_front();
					if (e.dz) n_dz++;
					if (e.tc == TC_MIN || e.tc == TC_MAX || e.pres == '1) n_sat++;
					if (temperature_centi !== e.tc) begin
						errors++;
						$display("%0t: temperature_centi expected %0d actual %0d", $time,
							$signed(e.tc), temperature_centi);
					end
					if (pressure_q24_8 !== e.pres) begin
						errors++;
						$display("%0t: pressure_q24_8 expected %0h actual %0h", $time,
							e.pres, pressure_q24_8);
					end
					if (divide_by_zero !== e.dz) begin
						errors++;
						$display("%0t: divide_by_zero expected %0b actual %0b", $time,
							e.dz, divide_by_zero);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap = gap_len();
			end
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TEMP_CAL:  tcal = val[TcalW-1:0];
			CFG_PRES_LOW:  pcal_lo = val;
			CFG_PRES_HIGH: pcal_hi = val;
			CFG_PRES_LAST: pcal_p9 = val[P9W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// calibration by mode: typical factory, extreme words, all zero, fully random or perturbed
	task automatic load_calibration(int mode);
		case (mode)
			0: begin
				write_reg(CFG_TEMP_CAL, 64'({16'hFC18, 16'h6A6E, 16'h6E5D}));
				write_reg(CFG_PRES_LOW, {16'h2710, 16'h0BD0, 16'hD6A3, 16'h8E81});
				write_reg(CFG_PRES_HIGH, {16'h0F38, 16'hC6F5, 16'h000F, 16'hFFF9});
				write_reg(CFG_PRES_LAST, 64'h1770);
			end
			1: begin
				write_reg(CFG_TEMP_CAL, 64'({16'h8000, 16'h7FFF, 16'hFFFF}));
				write_reg(CFG_PRES_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
				write_reg(CFG_PRES_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
				write_reg(CFG_PRES_LAST, 64'h8000);
			end
			2: begin
				write_reg(CFG_TEMP_CAL, 64'h0);
				write_reg(CFG_PRES_LOW, 64'h0);
				write_reg(CFG_PRES_HIGH, 64'h0);
				write_reg(CFG_PRES_LAST, 64'h0);
			end
			3: begin
				write_reg(CFG_TEMP_CAL, {$urandom, $urandom});
				write_reg(CFG_PRES_LOW, {$urandom, $urandom});
				write_reg(CFG_PRES_HIGH, {$urandom, $urandom});
				write_reg(CFG_PRES_LAST, {$urandom, $urandom});
			end
			default: begin
				write_reg(CFG_TEMP_CAL, 64'({16'h0000, 16'h8000 ^ 16'($urandom_range(0, 255)),
					16'h6000 + 16'($urandom_range(0, 8191))}));
				write_reg(CFG_PRES_LOW, {16'($urandom), 16'($urandom), 16'($urandom),
					16'h8000 + 16'($urandom_range(0, 32767))});
				write_reg(CFG_PRES_HIGH, {$urandom, $urandom});
				write_reg(CFG_PRES_LAST, 64'($urandom_range(0, 65535)));
			end
		endcase
	endtask

	function automatic raw_pair_t plausible_pair();
		return '{RawW'($urandom_range(380000, 640000)), RawW'($urandom_range(200000, 500000))};
	endfunction

	function automatic raw_pair_t any_pair();
		return '{RawW'($urandom), RawW'($urandom)};
	endfunction

	// stimulus
	initial begin
		tcal = '0;
		pcal_lo = '0;
		pcal_hi = '0;
		pcal_p9 = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// reset calibration gives a zero divisor
		pending_pairs.push_back('{RawW'(0), RawW'(0)});
		pending_pairs.push_back('{'1, '1});
		wait_drained();
		// directed corners under typical calibration
		load_calibration(0);
		pending_pairs.push_back('{RawW'(0), RawW'(0)});
		pending_pairs.push_back('{'1, '1});
		pending_pairs.push_back('{'1, RawW'(0)});
		pending_pairs.push_back('{RawW'(0), '1});
		pending_pairs.push_back('{RawW'(519888), RawW'(415148)});
		pending_pairs.push_back('{RawW'(20'h55555), RawW'(20'hAAAAA)});
		pending_pairs.push_back('{RawW'(20'hAAAAA), RawW'(20'h55555)});
		pending_pairs.push_back('{RawW'(1048576 - 1), RawW'(1)});
		wait_drained();
		// extreme calibration words, intermediate wrap
		load_calibration(1);
		for (int i = 0; i < 8; i++) pending_pairs.push_back(any_pair());
		pending_pairs.push_back('{RawW'(0), '1});
		pending_pairs.push_back('{'1, RawW'(0)});
		wait_drained();
		// random phases; long receiver stall in the first
		for (int ph = 0; ph < 8; ph++) begin
			load_calibration(ph == 7 ? 2 : (ph % 3 == 0 ? 0 : (ph % 3 == 1 ? 4 : 3)));
			if (ph == 0) hold_off = 400;
			for (int i = 0; i < 215; i++)
				pending_pairs.push_back(($urandom_range(0, 9) < 7) ? plausible_pair() : any_pair());
			wait_drained();
		end
		$display("Covered %0d results over 11 calibration settings, %0d zero-divisor, %0d saturated.",
			n_results, n_dz, n_sat);
		$display("Included a 400-cycle output stall and a drain before every calibration change.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run timeout
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
